@@ rtl/core/ctcm_pkg.sv @@
// Shared constants and types for the cost to color map pipeline.
package ctcm_pkg;

    localparam int COST_W  = 32;
    localparam int DIFF_W  = COST_W + 1;
    localparam int QUOT_W  = 16;
    localparam int CHAN_W  = 17;
    localparam int CFG_W   = COST_W;
    localparam int CIDX_W  = 2;

    localparam logic [CHAN_W-1:0] ONE_Q16 = CHAN_W'(65536);

    localparam logic [CIDX_W-1:0] CFG_MIN_COST   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_COST   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COLOR_MODE = 2'd2;

    localparam logic MODE_RAINBOW   = 1'b0;
    localparam logic MODE_RED_GREEN = 1'b1;

    typedef struct packed {
        logic [DIFF_W-1:0] rem;
        logic [DIFF_W-1:0] divisor;
        logic [QUOT_W-1:0] quot;
        logic              mode;
        logic              sat_lo;
        logic              sat_hi;
        logic              err;
    } div_word_t;

endpackage

@@ rtl/core/ctcm_front.sv @@
// Entry stage: range check, saturation flags and dividend setup.
module ctcm_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ctcm_pkg::COST_W-1:0]  s_cost_value,
    input  logic signed [ctcm_pkg::COST_W-1:0]  min_cost,
    input  logic signed [ctcm_pkg::COST_W-1:0]  max_cost,
    input  logic                                color_mode,
    output logic                                o_valid,
    input  logic                                o_ready,
    output ctcm_pkg::div_word_t                 o_word
);

    logic                                valid_reg;
    ctcm_pkg::div_word_t                 word_reg;
    ctcm_pkg::div_word_t                 word_next;
    logic signed [ctcm_pkg::DIFF_W-1:0]  lo_ext;
    logic signed [ctcm_pkg::DIFF_W-1:0]  hi_ext;
    logic signed [ctcm_pkg::DIFF_W-1:0]  cost_ext;

    assign lo_ext   = {min_cost[ctcm_pkg::COST_W-1], min_cost};
    assign hi_ext   = {max_cost[ctcm_pkg::COST_W-1], max_cost};
    assign cost_ext = {s_cost_value[ctcm_pkg::COST_W-1], s_cost_value};

    always_comb begin
        word_next.rem     = ctcm_pkg::DIFF_W'(cost_ext - lo_ext);
        word_next.divisor = ctcm_pkg::DIFF_W'(hi_ext - lo_ext);
        word_next.quot    = '0;
        word_next.mode    = color_mode;
        word_next.sat_lo  = (cost_ext <= lo_ext);
        word_next.sat_hi  = (cost_ext >= hi_ext);
        word_next.err     = (hi_ext <= lo_ext);
    end

    assign s_ready = !valid_reg || o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            word_reg <= word_next;
        end
    end

    assign o_valid = valid_reg;
    assign o_word  = word_reg;

endmodule

@@ rtl/core/ctcm_div_cell.sv @@
// One restoring division cell: produces one quotient bit per stage.
module ctcm_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 i_valid,
    output logic                 i_ready,
    input  ctcm_pkg::div_word_t  i_word,
    output logic                 o_valid,
    input  logic                 o_ready,
    output ctcm_pkg::div_word_t  o_word
);

    logic                          valid_reg;
    ctcm_pkg::div_word_t           word_reg;
    ctcm_pkg::div_word_t           word_next;
    logic [ctcm_pkg::DIFF_W:0]     shifted;
    logic [ctcm_pkg::DIFF_W:0]     trial;
    logic                          fits;

    assign shifted = {i_word.rem, 1'b0};
    assign trial   = shifted - {1'b0, i_word.divisor};
    assign fits    = (shifted >= {1'b0, i_word.divisor});

    always_comb begin
        word_next      = i_word;
        word_next.rem  = fits ? trial[ctcm_pkg::DIFF_W-1:0] : shifted[ctcm_pkg::DIFF_W-1:0];
        word_next.quot = {i_word.quot[ctcm_pkg::QUOT_W-2:0], fits};
    end

    assign i_ready = !valid_reg || o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (i_ready) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_ready && i_valid) begin
            word_reg <= word_next;
        end
    end

    assign o_valid = valid_reg;
    assign o_word  = word_reg;

endmodule

@@ rtl/core/ctcm_color.sv @@
// Output stage: clamps the quotient and maps it to an RGB word.
module ctcm_color (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               i_valid,
    output logic                               i_ready,
    input  ctcm_pkg::div_word_t                i_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ctcm_pkg::CHAN_W-1:0]        m_red,
    output logic [ctcm_pkg::CHAN_W-1:0]        m_green,
    output logic [ctcm_pkg::CHAN_W-1:0]        m_blue,
    output logic                               m_range_error
);

    localparam int H_W = ctcm_pkg::CHAN_W + 2;

    logic                         valid_reg;
    logic [ctcm_pkg::CHAN_W-1:0]  red_reg, green_reg, blue_reg;
    logic [ctcm_pkg::CHAN_W-1:0]  red_next, green_next, blue_next;
    logic                         err_reg;
    logic [ctcm_pkg::CHAN_W-1:0]  v;
    logic [H_W-1:0]               h;
    logic [2:0]                   seg;
    logic [ctcm_pkg::CHAN_W-1:0]  frac;
    logic [ctcm_pkg::CHAN_W-1:0]  n;
    logic [ctcm_pkg::CHAN_W:0]    rr;
    logic [ctcm_pkg::CHAN_W:0]    gg;

    always_comb begin
        if (i_word.sat_lo) begin
            v = '0;
        end else if (i_word.sat_hi) begin
            v = ctcm_pkg::ONE_Q16;
        end else begin
            v = {1'b0, i_word.quot};
        end
    end

    assign h    = {v, 2'b00} + H_W'(v) + H_W'(ctcm_pkg::ONE_Q16);
    assign seg  = h[H_W-1:16];
    assign frac = seg[0] ? {1'b0, h[15:0]} : ctcm_pkg::ONE_Q16 - {1'b0, h[15:0]};
    assign n    = ctcm_pkg::ONE_Q16 - frac;
    assign rr   = {v, 1'b0};
    assign gg   = {ctcm_pkg::ONE_Q16 - v, 1'b0};

    always_comb begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        if (i_word.err) begin
            red_next   = '0;
        end else if (i_word.mode == ctcm_pkg::MODE_RED_GREEN) begin
            red_next   = (rr > {1'b0, ctcm_pkg::ONE_Q16}) ? ctcm_pkg::ONE_Q16
                                                          : rr[ctcm_pkg::CHAN_W-1:0];
            green_next = (gg > {1'b0, ctcm_pkg::ONE_Q16}) ? ctcm_pkg::ONE_Q16
                                                          : gg[ctcm_pkg::CHAN_W-1:0];
        end else if (seg <= 3'd1) begin
            red_next   = n;
            blue_next  = ctcm_pkg::ONE_Q16;
        end else if (seg == 3'd2) begin
            green_next = n;
            blue_next  = ctcm_pkg::ONE_Q16;
        end else if (seg == 3'd3) begin
            green_next = ctcm_pkg::ONE_Q16;
            blue_next  = n;
        end else if (seg == 3'd4) begin
            red_next   = n;
            green_next = ctcm_pkg::ONE_Q16;
        end else begin
            red_next   = ctcm_pkg::ONE_Q16;
            green_next = n;
        end
    end

    assign i_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (i_ready) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_ready && i_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            err_reg   <= i_word.err;
        end
    end

    assign m_valid       = valid_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;
    assign m_range_error = err_reg;

    // empty range gives black
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> (m_red == '0) && (m_green == '0) && (m_blue == '0))
        else $error("range error with nonzero color");

    // every valid color has one channel at full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_error |->
            (m_red == ctcm_pkg::ONE_Q16) || (m_green == ctcm_pkg::ONE_Q16) ||
            (m_blue == ctcm_pkg::ONE_Q16))
        else $error("no full-scale channel");

    // channels never exceed 1.0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red <= ctcm_pkg::ONE_Q16) && (m_green <= ctcm_pkg::ONE_Q16) &&
                    (m_blue <= ctcm_pkg::ONE_Q16))
        else $error("channel above full scale");

endmodule

@@ rtl/core/cost_to_color_map_top.sv @@
// Top level of the cost to color map: config registers and the pipeline.
//
// Usage: each word on the s_ channel carries one signed Q16.16 cost. Each
// accepted word yields exactly one word on the m_ channel: red, green and
// blue in Q1.16 (65536 is full scale) plus range_error, in input order.
// Both channels use valid/ready; a word moves when both are high.
// The word is registered in one entry stage, then in 16 divider cells (one
// quotient bit each, a compare and subtract per cell), then in one color
// stage. Throughput is one word per cycle while m_ready stays high.
// Every stage holds its own valid bit, so bubbles close up; when m_ready is
// low the pipeline keeps accepting until all 18 stages are full, then
// s_ready drops and data holds in place.
// Registers min_cost, max_cost and color_mode are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no word is in
// flight, as the block does not enforce this. Reset (aresetn low, synchronous)
// empties the pipeline and loads min_cost 0, max_cost 1.0 and rainbow mode.
module cost_to_color_map_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ctcm_pkg::COST_W-1:0]  s_cost_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ctcm_pkg::CHAN_W-1:0]         m_red,
    output logic [ctcm_pkg::CHAN_W-1:0]         m_green,
    output logic [ctcm_pkg::CHAN_W-1:0]         m_blue,
    output logic                                m_range_error,
    input  logic                                cfg_we,
    input  logic [ctcm_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [ctcm_pkg::CFG_W-1:0]          cfg_data
);

    logic signed [ctcm_pkg::COST_W-1:0]  min_cost_reg;
    logic signed [ctcm_pkg::COST_W-1:0]  max_cost_reg;
    logic                                color_mode_reg;

    logic                 stg_valid [0:ctcm_pkg::QUOT_W];
    logic                 stg_ready [0:ctcm_pkg::QUOT_W];
    ctcm_pkg::div_word_t  stg_word  [0:ctcm_pkg::QUOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cost_reg   <= '0;
            max_cost_reg   <= ctcm_pkg::COST_W'(65536);
            color_mode_reg <= ctcm_pkg::MODE_RAINBOW;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ctcm_pkg::CFG_MIN_COST:   min_cost_reg   <= cfg_data[ctcm_pkg::COST_W-1:0];
                ctcm_pkg::CFG_MAX_COST:   max_cost_reg   <= cfg_data[ctcm_pkg::COST_W-1:0];
                ctcm_pkg::CFG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    ctcm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cost_value (s_cost_value),
        .min_cost     (min_cost_reg),
        .max_cost     (max_cost_reg),
        .color_mode   (color_mode_reg),
        .o_valid      (stg_valid[0]),
        .o_ready      (stg_ready[0]),
        .o_word       (stg_word[0])
    );

    for (genvar k = 0; k < ctcm_pkg::QUOT_W; k++) begin : g_div
        ctcm_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .i_valid (stg_valid[k]),
            .i_ready (stg_ready[k]),
            .i_word  (stg_word[k]),
            .o_valid (stg_valid[k+1]),
            .o_ready (stg_ready[k+1]),
            .o_word  (stg_word[k+1])
        );
    end

    ctcm_color u_color (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .i_valid       (stg_valid[ctcm_pkg::QUOT_W]),
        .i_ready       (stg_ready[ctcm_pkg::QUOT_W]),
        .i_word        (stg_word[ctcm_pkg::QUOT_W]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_range_error (m_range_error)
    );

endmodule

@@ sim/cost_to_color_map_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cost_to_color_map_top: random costs, config sweeps, color prediction.
module cost_to_color_map_top_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam int BATCH_WORDS    = 90;

    typedef struct packed {
        bit [ctcm_pkg::CHAN_W-1:0] red;
        bit [ctcm_pkg::CHAN_W-1:0] green;
        bit [ctcm_pkg::CHAN_W-1:0] blue;
        bit                        range_error;
    } color_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic signed [ctcm_pkg::COST_W-1:0] s_cost_value = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [ctcm_pkg::CHAN_W-1:0]        m_red;
    logic [ctcm_pkg::CHAN_W-1:0]        m_green;
    logic [ctcm_pkg::CHAN_W-1:0]        m_blue;
    logic                               m_range_error;
    logic                               cfg_we = 1'b0;
    logic [ctcm_pkg::CIDX_W-1:0]        cfg_index = '0;
    logic [ctcm_pkg::CFG_W-1:0]         cfg_data = '0;

    logic signed [ctcm_pkg::COST_W-1:0] lim_lo = '0;
    logic signed [ctcm_pkg::COST_W-1:0] lim_hi = ctcm_pkg::COST_W'(65536);
    logic                               scale_mode = ctcm_pkg::MODE_RAINBOW;

    logic signed [ctcm_pkg::COST_W-1:0] pending_costs[$];
    color_t                             expected_colors[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int fail_count        = 0;
    int words_out         = 0;
    int range_errors_seen = 0;
    int settings_written  = 0;
    int idle_cycles       = 0;

    cost_to_color_map_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cost_value (s_cost_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_range_error(m_range_error),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic color_t predict_color(logic signed [ctcm_pkg::COST_W-1:0] cost);
        longint      lo;
        longint      hi;
        longint      c;
        int unsigned v;
        int unsigned h;
        int unsigned i;
        int unsigned f;
        int unsigned n;
        int unsigned rr;
        int unsigned gg;
        color_t      col;
        lo = lim_lo;
        hi = lim_hi;
        c = cost;
        col = '0;
        if (hi <= lo) begin
            col.range_error = 1'b1;
            return col;
        end
        if (c <= lo)
            v = 0;
        else if (c >= hi)
            v = 65536;
        else
            v = int'(((c - lo) <<< 16) / (hi - lo));
        if (scale_mode == ctcm_pkg::MODE_RED_GREEN) begin
            rr = 2 * v;
            gg = 2 * (65536 - v);
            col.red   = ctcm_pkg::CHAN_W'((rr > 65536) ? 65536 : rr);
            col.green = ctcm_pkg::CHAN_W'((gg > 65536) ? 65536 : gg);
            col.blue  = '0;
        end else begin
            h = 5 * v + 65536;
            i = h >> 16;
            f = h & 32'hFFFF;
            if ((i & 1) == 0)
                f = 65536 - f;
            n = 65536 - f;
            if (i <= 1) begin
                col.red = ctcm_pkg::CHAN_W'(n); col.green = '0;
                col.blue = ctcm_pkg::ONE_Q16;
            end else if (i == 2) begin
                col.red = '0; col.green = ctcm_pkg::CHAN_W'(n);
                col.blue = ctcm_pkg::ONE_Q16;
            end else if (i == 3) begin
                col.red = '0; col.green = ctcm_pkg::ONE_Q16;
                col.blue = ctcm_pkg::CHAN_W'(n);
            end else if (i == 4) begin
                col.red = ctcm_pkg::CHAN_W'(n); col.green = ctcm_pkg::ONE_Q16;
                col.blue = '0;
            end else begin
                col.red = ctcm_pkg::ONE_Q16; col.green = ctcm_pkg::CHAN_W'(n);
                col.blue = '0;
            end
        end
        return col;
    endfunction

    // mostly in-range costs, some near the limits, the rest anywhere
    function automatic logic signed [ctcm_pkg::COST_W-1:0] random_cost();
        longint          lo;
        longint          hi;
        longint unsigned r;
        int              roll;
        lo = lim_lo;
        hi = lim_hi;
        roll = $urandom_range(99);
        r = {$urandom, $urandom};
        if (roll < 60 && hi > lo)
            return ctcm_pkg::COST_W'(lo + longint'(r % longint'(hi - lo + 1)));
        if (roll < 80)
            return ctcm_pkg::COST_W'(($urandom_range(1) ? lo : hi) + $urandom_range(8) - 4);
        return ctcm_pkg::COST_W'($urandom);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
        end else if (pending_costs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            s_valid      <= 1'b1;
            s_cost_value <= pending_costs.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        color_t exp_col;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_colors = {expected_colors, predict_color(s_cost_value)};
            if (m_valid && m_ready) begin
                words_out++;
                if (m_range_error)
                    range_errors_seen++;
                if (expected_colors.size() == 0) begin
                    $error("unexpected color word: red %0d green %0d blue %0d err %0d",
                           m_red, m_green, m_blue, m_range_error);
                    fail_count++;
                end else begin
                    exp_col = expected_colors.pop_front();
                    if (m_red !== exp_col.red) begin
                        $error("red mismatch: expected %0d, actual %0d", exp_col.red, m_red);
                        fail_count++;
                    end
                    if (m_green !== exp_col.green) begin
                        $error("green mismatch: expected %0d, actual %0d",
                               exp_col.green, m_green);
                        fail_count++;
                    end
                    if (m_blue !== exp_col.blue) begin
                        $error("blue mismatch: expected %0d, actual %0d", exp_col.blue, m_blue);
                        fail_count++;
                    end
                    if (m_range_error !== exp_col.range_error) begin
                        $error("range_error mismatch: expected %0d, actual %0d",
                               exp_col.range_error, m_range_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // checked mid-cycle so every edge update has settled
    task automatic wait_until_idle();
        do
            @(negedge aclk);
        while (pending_costs.size() > 0 || expected_colors.size() > 0 || s_valid);
    endtask

    task automatic write_config(logic signed [ctcm_pkg::COST_W-1:0] lo,
                                logic signed [ctcm_pkg::COST_W-1:0] hi,
                                logic [ctcm_pkg::CFG_W-1:0] mode_word);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= ctcm_pkg::CFG_MIN_COST;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_index <= ctcm_pkg::CFG_MAX_COST;
        cfg_data  <= hi;
        @(posedge aclk);
        cfg_index <= ctcm_pkg::CFG_COLOR_MODE;
        cfg_data  <= mode_word;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        lim_lo     = lo;
        lim_hi     = hi;
        scale_mode = mode_word[0];
        settings_written++;
    endtask

    task automatic push_random(int count);
        repeat (count) pending_costs = {pending_costs, random_cost()};
    endtask

    initial begin
        longint lo;
        longint hi;
        int     phase;
        int     kind;
        logic   mode_bit;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        sender_idle_pct   = 8;
        receiver_idle_pct = 50;

        // reset defaults: rainbow, 0..1.0; segment edges and cost extremes
        pending_costs = '{32'sd0, -32'sd1, 32'sd65536, 32'sd65537, 32'sh8000_0000,
                          32'sh7FFF_FFFF, 32'sd13107, 32'sd13108, 32'sd26214, 32'sd32768,
                          32'sd52429, 32'sd65535, 32'sd1};
        wait_until_idle();

        write_config(32'sd0, 32'sd65536, {31'h5A5A_5A5A, ctcm_pkg::MODE_RED_GREEN});
        pending_costs = '{32'sd0, 32'sd32768, 32'sd32767, 32'sd16384, 32'sd65536, 32'sd49152};
        wait_until_idle();

        // empty ranges: equal limits, then inverted extremes
        write_config(32'sd100, 32'sd100, {31'h0, ctcm_pkg::MODE_RAINBOW});
        pending_costs = '{32'sd100, 32'sh8000_0000};
        wait_until_idle();
        write_config(32'sh7FFF_FFFF, 32'sh8000_0000, {31'h7FFF_FFFF, ctcm_pkg::MODE_RAINBOW});
        pending_costs = '{32'sd0, 32'sh7FFF_FFFF};
        wait_until_idle();

        write_config(32'sh8000_0000, 32'sh7FFF_FFFF, {31'h0, ctcm_pkg::MODE_RAINBOW});
        pending_costs = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0};
        wait_until_idle();

        for (phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 8 : (phase == 1) ? 50 : 0;
            receiver_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 8 : 0;
            for (kind = 0; kind < 6; kind++) begin
                mode_bit = kind[0] ^ phase[0];
                case (kind)
                    0: begin
                        lo = longint'($signed($urandom));
                        hi = longint'($signed($urandom));
                        if (lo > hi) begin
                            lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
                        end
                        if (lo == hi)
                            lo = hi - 1;
                    end
                    1: begin
                        lo = -64'sd2147483648;
                        hi = 64'sd2147483647;
                    end
                    2: begin
                        hi = longint'($signed($urandom));
                        if (hi < -64'sd2147483600)
                            hi = 0;
                        lo = hi - $urandom_range(16, 1);
                    end
                    3: begin
                        lo = longint'($signed($urandom));
                        hi = lo - $urandom_range(1000);
                        if (hi < -64'sd2147483648)
                            hi = lo;
                    end
                    4: begin
                        lo = -longint'($urandom_range(1 << 20));
                        hi = longint'($urandom_range(1 << 22, 1));
                    end
                    default: begin
                        lo = 0;
                        hi = 65536;
                    end
                endcase
                write_config(ctcm_pkg::COST_W'(lo), ctcm_pkg::COST_W'(hi),
                             {$urandom_range(1) ? 31'h0 : 31'($urandom), mode_bit});
                if (kind == 2) begin
                    // sender holds off until the pipeline has fully drained
                    push_random(BATCH_WORDS / 2);
                    wait_until_idle();
                    push_random(BATCH_WORDS - BATCH_WORDS / 2);
                end else begin
                    push_random(BATCH_WORDS);
                end
                wait_until_idle();
            end
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_colors.size() != 0) begin
            $error("%0d color words never arrived", expected_colors.size());
            fail_count++;
        end

        $display("Checked %0d color words across %0d register settings, %0d with range error,",
                 words_out, settings_written, range_errors_seen);
        $display("both scales, extreme and empty cost ranges, and three stall patterns.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
